// ----- rtl/sra_pkg.sv -----
`timescale 1ns / 1ps
package sra_pkg;

	localparam int WINDOW       = 4;
	localparam int SEQ_MAX      = 7;
	localparam int SEQ_MOD      = SEQ_MAX + 1;
	localparam int PAYLOAD_BITS = 32;
	localparam int SEQ_W        = 3;
	localparam int SLOT_W       = 2;
	localparam int BUF_W        = 3;
	localparam int CNT_W        = 4;

	typedef logic [SEQ_W-1:0]        seq_t;
	typedef logic [SLOT_W-1:0]       slot_t;
	typedef logic [PAYLOAD_BITS-1:0] payload_t;

	localparam logic [2:0] CMD_PACKET  = 3'd0;
	localparam logic [2:0] CMD_ARRIVAL = 3'd1;
	localparam logic [2:0] CMD_CKSUM   = 3'd2;
	localparam logic [2:0] CMD_RTO     = 3'd3;
	localparam logic [2:0] CMD_ATO     = 3'd4;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_ACK  = 2'd1;
	localparam logic [1:0] KIND_NAK  = 2'd2;

	localparam logic [1:0] RES_TX      = 2'd0;
	localparam logic [1:0] RES_DELIVER = 2'd1;
	localparam logic [1:0] RES_STATUS  = 2'd2;

	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_STOP  = 2'd2;

	typedef struct packed {
		logic [1:0]     result_kind;
		logic [1:0]     tx_kind;
		seq_t           tx_seq;
		seq_t           tx_ack;
		payload_t       payload_out;
		logic           start_timer_valid;
		slot_t          start_timer_slot;
		logic [WINDOW-1:0] stop_timer_mask;
		logic [1:0]     ack_timer_action;
		logic           network_enable;
		logic           window_full_error;
		logic           last;
	} res_t;

	function automatic seq_t seq_next(input seq_t x);
		seq_t r;
		if (x >= SEQ_W'(SEQ_MAX)) begin
			r = '0;
		end else begin
			r = x + 1'b1;
		end
		return r;
	endfunction

endpackage

// ----- rtl/sra_in_if.sv -----
`timescale 1ns / 1ps
interface sra_in_if;
	logic                 valid;
	logic                 ready;
	logic [2:0]           command;
	sra_pkg::payload_t    packet_in;
	logic [1:0]           rx_kind;
	sra_pkg::seq_t        rx_seq;
	sra_pkg::seq_t        rx_ack;
	sra_pkg::payload_t    rx_payload;
	sra_pkg::seq_t        timeout_seq;

	modport source (output valid, command, packet_in, rx_kind, rx_seq, rx_ack, rx_payload,
		timeout_seq, input ready);
	modport sink (input valid, command, packet_in, rx_kind, rx_seq, rx_ack, rx_payload,
		timeout_seq, output ready);
endinterface

// ----- rtl/sra_out_if.sv -----
`timescale 1ns / 1ps
interface sra_out_if;
	logic              valid;
	logic              ready;
	logic [1:0]        result_kind;
	logic [1:0]        tx_kind;
	sra_pkg::seq_t     tx_seq;
	sra_pkg::seq_t     tx_ack;
	sra_pkg::payload_t payload_out;
	logic              start_timer_valid;
	sra_pkg::slot_t    start_timer_slot;
	logic [3:0]        stop_timer_mask;
	logic [1:0]        ack_timer_action;
	logic              network_enable;
	logic              window_full_error;
	logic              last;

	modport source (output valid, result_kind, tx_kind, tx_seq, tx_ack, payload_out,
		start_timer_valid, start_timer_slot, stop_timer_mask, ack_timer_action,
		network_enable, window_full_error, last, input ready);
	modport sink (input valid, result_kind, tx_kind, tx_seq, tx_ack, payload_out,
		start_timer_valid, start_timer_slot, stop_timer_mask, ack_timer_action,
		network_enable, window_full_error, last, output ready);
endinterface

// ----- rtl/sra_range_unit.sv -----
`timescale 1ns / 1ps
module sra_range_unit (
	input  sra_pkg::seq_t lo,
	input  sra_pkg::seq_t val,
	input  sra_pkg::seq_t hi,
	output logic          hit
);
	import sra_pkg::*;

	// circular test lo <= val < hi over the sequence space
	assign hit = ((lo <= val) && (val < hi)) || ((hi < lo) && (lo <= val)) ||
		((val < hi) && (hi < lo));
endmodule

// ----- rtl/selective_repeat_arq_endpoint_core.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Handshake      Content
// req      in   valid/ready    one event: command, packet, arrived frame, timeout seq
// res      out  valid/ready    transmitted frames, deliveries, then one status item
//
// One event runs a dispatch step, a store step for an arrived data frame, a walk over the
// delivered packets (at most a window) and one over the acked frames (bounded by the
// sequence space), each walk ending in an exit step and done by the sequencer through
// one shared window-range comparator; each result item waits for its output register.
// req.ready is high only between events. res holds while res.ready is low.
// arst_n clears window edges (the receive upper edge is set to WINDOW), counters, arrival map and the output register.
module selective_repeat_arq_endpoint_core (
	input  logic        clk,
	input  logic        arst_n,
	sra_in_if.sink      req,
	sra_out_if.source   res
);
	import sra_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_EXEC    = 6'b000010,
		S_STORE   = 6'b000100,
		S_DELIVER = 6'b001000,
		S_ACKW    = 6'b010000,
		S_STATUS  = 6'b100000
	} state_t;

	state_t state_q;

	seq_t sle_q, snext_q, rle_q, rue_q;
	logic [BUF_W-1:0] biu_q;
	logic nak_q;
	logic [WINDOW-1:0] map_q;
	logic [WINDOW-1:0] stop_q;
	logic [1:0] act_q;
	logic err_q;
	logic [CNT_W-1:0] cnt_q;
	logic ov_q;
	res_t res_q;

	logic [2:0] cmd_q;
	payload_t pkt_q, rpay_q;
	logic [1:0] kind_q;
	seq_t seq_q, rack_q, tseq_q;

	payload_t obuf [WINDOW];
	payload_t ibuf [WINDOW];

	seq_t r_lo, r_val, r_hi;
	logic hit;
	seq_t target;
	logic full, nak_cond, deliver_go, walk_go, can_emit, need_emit, step, emit_en;
	logic req_fire, obuf_we, ibuf_we;
	seq_t obuf_rseq;
	res_t er;

	sra_range_unit u_range (.lo(r_lo), .val(r_val), .hi(r_hi), .hit(hit));

	assign target     = seq_next(rack_q);
	assign full       = biu_q >= BUF_W'(WINDOW);
	assign nak_cond   = (seq_q != rle_q) && nak_q;
	assign deliver_go = (cnt_q < CNT_W'(WINDOW)) && map_q[rle_q[SLOT_W-1:0]];
	assign walk_go    = (cnt_q < CNT_W'(SEQ_MOD)) && hit;
	assign can_emit   = !ov_q || res.ready;
	assign req.ready  = (state_q == S_IDLE);
	assign req_fire   = req.valid && req.ready;
	assign obuf_rseq  = (cmd_q == CMD_RTO) ? tseq_q : target;

	always_comb begin
		case (state_q)
			S_EXEC: begin
				r_lo = sle_q; r_val = target; r_hi = snext_q;
			end
			S_STORE: begin
				r_lo = rle_q; r_val = seq_q; r_hi = rue_q;
			end
			default: begin
				r_lo = sle_q; r_val = rack_q; r_hi = snext_q;
			end
		endcase
	end

	always_comb begin
		need_emit = 1'b0;
		er = '0;
		case (state_q)
			S_EXEC: begin
				er.result_kind = RES_TX;
				er.tx_ack = SEQ_W'(rle_q + SEQ_W'(SEQ_MAX));
				case (cmd_q)
					CMD_PACKET: begin
						if (!full) begin
							need_emit = 1'b1;
							er.tx_kind = KIND_DATA;
							er.tx_seq = snext_q;
							er.payload_out = pkt_q;
							er.start_timer_valid = 1'b1;
							er.start_timer_slot = snext_q[SLOT_W-1:0];
						end
					end
					CMD_ARRIVAL: begin
						if (kind_q == KIND_DATA && nak_cond) begin
							need_emit = 1'b1;
							er.tx_kind = KIND_NAK;
						end else if (kind_q == KIND_NAK && hit) begin
							need_emit = 1'b1;
							er.tx_kind = KIND_DATA;
							er.tx_seq = obuf_rseq;
							er.payload_out = obuf[obuf_rseq[SLOT_W-1:0]];
							er.start_timer_valid = 1'b1;
							er.start_timer_slot = obuf_rseq[SLOT_W-1:0];
						end
					end
					CMD_CKSUM: begin
						if (nak_q) begin
							need_emit = 1'b1;
							er.tx_kind = KIND_NAK;
						end
					end
					CMD_RTO: begin
						need_emit = 1'b1;
						er.tx_kind = KIND_DATA;
						er.tx_seq = obuf_rseq;
						er.payload_out = obuf[obuf_rseq[SLOT_W-1:0]];
						er.start_timer_valid = 1'b1;
						er.start_timer_slot = obuf_rseq[SLOT_W-1:0];
					end
					CMD_ATO: begin
						need_emit = 1'b1;
						er.tx_kind = KIND_ACK;
					end
					default: begin
						need_emit = 1'b0;
					end
				endcase
			end
			S_DELIVER: begin
				if (deliver_go) begin
					need_emit = 1'b1;
					er.result_kind = RES_DELIVER;
					er.payload_out = ibuf[rle_q[SLOT_W-1:0]];
				end
			end
			S_STATUS: begin
				need_emit = 1'b1;
				er.result_kind = RES_STATUS;
				er.stop_timer_mask = stop_q;
				er.ack_timer_action = act_q;
				er.network_enable = !full;
				er.window_full_error = err_q;
				er.last = 1'b1;
			end
			default: begin
				need_emit = 1'b0;
			end
		endcase
	end

	assign step    = !need_emit || can_emit;
	assign emit_en = need_emit && can_emit;
	assign obuf_we = (state_q == S_EXEC) && (cmd_q == CMD_PACKET) && !full && step;
	assign ibuf_we = (state_q == S_STORE) && hit && !map_q[seq_q[SLOT_W-1:0]];

	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q  <= req.command;
			pkt_q  <= req.packet_in;
			kind_q <= req.rx_kind;
			seq_q  <= req.rx_seq;
			rack_q <= req.rx_ack;
			rpay_q <= req.rx_payload;
			tseq_q <= req.timeout_seq;
		end
		if (obuf_we) begin
			obuf[snext_q[SLOT_W-1:0]] <= pkt_q;
		end
		if (ibuf_we) begin
			ibuf[seq_q[SLOT_W-1:0]] <= rpay_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sle_q   <= '0;
			snext_q <= '0;
			rle_q   <= '0;
			rue_q   <= SEQ_W'(WINDOW % SEQ_MOD);
			biu_q   <= '0;
			nak_q   <= 1'b1;
			map_q   <= '0;
			stop_q  <= '0;
			act_q   <= ACT_NONE;
			err_q   <= 1'b0;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
			res_q   <= '0;
		end else begin
			if (emit_en) begin
				ov_q  <= 1'b1;
				res_q <= er;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						act_q   <= ACT_NONE;
						stop_q  <= '0;
						err_q   <= 1'b0;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (step) begin
						cnt_q   <= '0;
						state_q <= S_STATUS;
						case (cmd_q)
							CMD_PACKET: begin
								if (full) begin
									err_q <= 1'b1;
								end else begin
									biu_q   <= biu_q + 1'b1;
									snext_q <= seq_next(snext_q);
									act_q   <= ACT_STOP;
								end
							end
							CMD_ARRIVAL: begin
								if (kind_q == KIND_DATA) begin
									state_q <= S_STORE;
									if (nak_cond) begin
										nak_q <= 1'b0;
										act_q <= ACT_STOP;
									end else begin
										act_q <= ACT_START;
									end
								end else begin
									state_q <= S_ACKW;
									if (kind_q == KIND_NAK && hit) begin
										act_q <= ACT_STOP;
									end
								end
							end
							CMD_CKSUM: begin
								if (nak_q) begin
									nak_q <= 1'b0;
									act_q <= ACT_STOP;
								end
							end
							CMD_RTO, CMD_ATO: begin
								act_q <= ACT_STOP;
							end
							default: begin
								act_q <= ACT_NONE;
							end
						endcase
					end
				end
				S_STORE: begin
					cnt_q <= '0;
					if (ibuf_we) begin
						map_q[seq_q[SLOT_W-1:0]] <= 1'b1;
						state_q <= S_DELIVER;
					end else begin
						state_q <= S_ACKW;
					end
				end
				S_DELIVER: begin
					if (!deliver_go) begin
						cnt_q   <= '0;
						state_q <= S_ACKW;
					end else if (step) begin
						// hand over in-order packet, slide receive window
						map_q[rle_q[SLOT_W-1:0]] <= 1'b0;
						rle_q <= seq_next(rle_q);
						rue_q <= seq_next(rue_q);
						nak_q <= 1'b1;
						act_q <= ACT_START;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ACKW: begin
					if (walk_go) begin
						if (biu_q != '0) begin
							biu_q <= biu_q - 1'b1;
						end
						stop_q[sle_q[SLOT_W-1:0]] <= 1'b1;
						sle_q <= seq_next(sle_q);
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= S_STATUS;
					end
				end
				S_STATUS: begin
					if (step) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.valid             = ov_q;
	assign res.result_kind       = res_q.result_kind;
	assign res.tx_kind           = res_q.tx_kind;
	assign res.tx_seq            = res_q.tx_seq;
	assign res.tx_ack            = res_q.tx_ack;
	assign res.payload_out       = res_q.payload_out;
	assign res.start_timer_valid = res_q.start_timer_valid;
	assign res.start_timer_slot  = res_q.start_timer_slot;
	assign res.stop_timer_mask   = res_q.stop_timer_mask;
	assign res.ack_timer_action  = res_q.ack_timer_action;
	assign res.network_enable    = res_q.network_enable;
	assign res.window_full_error = res_q.window_full_error;
	assign res.last              = res_q.last;
endmodule
